/* rtl/wrpp_pkg.sv */
// ----------------------------------------------------------------------------
// wrpp_pkg: shared types and constants for the weighted region page picker
// entry layout, item kinds, status codes and cell control
// ----------------------------------------------------------------------------
package wrpp_pkg;

  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned SIZE_W          = 40;
  localparam int unsigned DRAW_W          = 44;
  localparam int unsigned SHIFT_W         = 5;
  localparam int unsigned MAX_REGIONS_DEF = 16;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(12);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_PICK   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // one table entry held by a cell
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] length;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;      // move the row one place toward the head
    logic take_head;  // on shift, load the head entry instead of the neighbor
    logic wr;         // load a new entry from the add path
  } cell_ctl_t;

endpackage

/* rtl/wrpp_cell.sv */
// ----------------------------------------------------------------------------
// wrpp_cell: one slot of the region row
// holds one entry and takes its neighbor, the head or a new entry
// ----------------------------------------------------------------------------
module wrpp_cell (
  input  logic                clk_i,
  input  wrpp_pkg::cell_ctl_t ctl_i,
  input  wrpp_pkg::entry_t    neighbor_i,
  input  wrpp_pkg::entry_t    head_i,
  input  wrpp_pkg::entry_t    wr_entry_i,
  output wrpp_pkg::entry_t    entry_o
);

  wrpp_pkg::entry_t entry_q;
  wrpp_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = ctl_i.take_head ? head_i : neighbor_i;
    end else if (ctl_i.wr) begin
      entry_d = wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/weighted_region_page_picker.sv */
// ----------------------------------------------------------------------------
// weighted_region_page_picker: roulette-wheel page selection over a region table
// ordered table of regions kept in a row of cells that rotates through the head
// ----------------------------------------------------------------------------
// usage
//   input channel: kind_i with region_address_i, region_size_i, draw_position_i,
//   taken when in_valid_i is high and in_stall_o is low. one item at a time.
//   output channel: page_address_o, status_o, total_bytes_o, one result per
//   item, delivered when out_valid_o is high and out_stall_i is low.
//   config: cfg_data_i writes page_shift whenever cfg_valid_i is high
//   (cfg_ready_o is always high); write it only while the block is idle.
// item flow
//   add and clear: the result is settled when the item is taken and moves on
//   to the output register as soon as that register frees up.
//   pick and delete: the row rotates once per stored region through the head,
//   then the walk settles the result, which then moves to the output register.
//   the next item is taken in the cycle after the result is loaded.
// reset
//   table empty, byte total zero, page_shift 12, no result pending.
// stall
//   a result waits in the output register; a finished next result waits in
//   the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module weighted_region_page_picker #(
  parameter int unsigned MAX_REGIONS = wrpp_pkg::MAX_REGIONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [wrpp_pkg::ADDR_W-1:0]  region_address_i,
  input  logic [wrpp_pkg::SIZE_W-1:0]  region_size_i,
  input  logic [wrpp_pkg::DRAW_W-1:0]  draw_position_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wrpp_pkg::ADDR_W-1:0]  page_address_o,
  output logic [1:0]                   status_o,
  output logic [wrpp_pkg::DRAW_W-1:0]  total_bytes_o,
  // page_shift register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wrpp_pkg::SHIFT_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);  // count width
  localparam int unsigned IW = $clog2(MAX_REGIONS);      // cell index width

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [CW-1:0]                   count_q;   // stored regions
  logic [CW-1:0]                   len_q;     // live ring length during a walk
  logic [CW-1:0]                   rem_q;     // walk steps left
  logic [wrpp_pkg::DRAW_W-1:0]     total_q;
  logic [wrpp_pkg::SHIFT_W-1:0]    shift_q;
  wrpp_pkg::kind_e                 kind_q;
  logic [wrpp_pkg::ADDR_W-1:0]     key_q;
  logic [wrpp_pkg::DRAW_W-1:0]     pos_q;
  logic                            found_q;
  logic [wrpp_pkg::ADDR_W-1:0]     hit_base_q;
  logic [wrpp_pkg::SIZE_W-1:0]     hit_off_q;
  wrpp_pkg::status_e               res_status_q;
  logic [wrpp_pkg::ADDR_W-1:0]     res_addr_q;
  logic                            out_valid_q;
  logic [wrpp_pkg::ADDR_W-1:0]     out_addr_q;
  wrpp_pkg::status_e               out_status_q;
  logic [wrpp_pkg::DRAW_W-1:0]     out_total_q;

  wrpp_pkg::entry_t                cells   [MAX_REGIONS];
  wrpp_pkg::cell_ctl_t             cell_ctl[MAX_REGIONS];
  wrpp_pkg::entry_t                head;
  wrpp_pkg::entry_t                new_entry;

  logic                            accept;
  logic                            step;
  logic                            drop;
  logic                            add_we;
  logic [CW-1:0]                   tail_idx;
  logic [wrpp_pkg::DRAW_W-1:0]     head_len;
  logic                            inside_hit;
  logic [wrpp_pkg::ADDR_W-1:0]     hit_sum;
  logic [wrpp_pkg::ADDR_W-1:0]     hit_page;
  logic                            out_free;
  wrpp_pkg::kind_e                 kind_in;

  assign kind_in     = wrpp_pkg::kind_e'(kind_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // the head is cell 0; the walk rotates each entry through it
  assign head     = cells[0];
  assign head_len = wrpp_pkg::DRAW_W'(head.length);

  // one rotation step per cycle while stored regions remain
  assign step = (state_q == S_WALK) && (rem_q != '0);

  // delete drops the first matching head from the ring
  assign drop = step && (kind_q == wrpp_pkg::KIND_DELETE) && !found_q
                && (head.base == key_q);

  // pick: the draw falls inside the head region
  assign inside_hit = (pos_q < head_len);

  assign tail_idx = len_q - CW'(1);

  // append at the end of the table when there is room
  assign add_we    = accept && (kind_in == wrpp_pkg::KIND_ADD)
                     && (count_q < CW'(MAX_REGIONS));
  assign new_entry = '{base: region_address_i, length: region_size_i};

  // row of cells: each moves one place toward the head; the tail of the
  // live ring takes the head back unless it is being dropped
  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    wrpp_pkg::entry_t neighbor;

    if (i == MAX_REGIONS - 1) begin : g_last
      assign neighbor = head;
    end else begin : g_mid
      assign neighbor = cells[i+1];
    end

    assign cell_ctl[i].shift     = step;
    assign cell_ctl[i].take_head = (tail_idx == CW'(i)) && !drop;
    assign cell_ctl[i].wr        = add_we && (count_q[IW-1:0] == IW'(i));

    wrpp_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl[i]),
      .neighbor_i (neighbor),
      .head_i     (head),
      .wr_entry_i (new_entry),
      .entry_o    (cells[i])
    );
  end

  // chosen address, rounded down to the start of its page
  assign hit_sum  = hit_base_q + wrpp_pkg::ADDR_W'(hit_off_q);
  assign hit_page = (hit_sum >> shift_q) << shift_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      total_q     <= '0;
      shift_q     <= wrpp_pkg::PAGE_SHIFT_RST;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        shift_q <= cfg_data_i;
      end

      // in the done state a taken result is replaced by the next one below
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q     <= kind_in;
            key_q      <= region_address_i;
            pos_q      <= draw_position_i;
            found_q    <= 1'b0;
            len_q      <= count_q;
            rem_q      <= count_q;
            res_addr_q <= '0;
            case (kind_in)
              wrpp_pkg::KIND_ADD: begin
                if (count_q < CW'(MAX_REGIONS)) begin
                  count_q      <= count_q + CW'(1);
                  total_q      <= total_q + wrpp_pkg::DRAW_W'(region_size_i);
                  res_status_q <= wrpp_pkg::ST_OK;
                end else begin
                  res_status_q <= wrpp_pkg::ST_FULL;
                end
                state_q <= S_DONE;
              end
              wrpp_pkg::KIND_CLEAR: begin
                count_q      <= '0;
                total_q      <= '0;
                res_status_q <= wrpp_pkg::ST_OK;
                state_q      <= S_DONE;
              end
              default: begin
                state_q <= S_WALK;
              end
            endcase
          end
        end

        S_WALK: begin
          if (step) begin
            rem_q <= rem_q - CW'(1);
            if (drop) begin
              found_q <= 1'b1;
              len_q   <= len_q - CW'(1);
              total_q <= total_q - head_len;
            end
            if (kind_q == wrpp_pkg::KIND_PICK && !found_q) begin
              if (inside_hit) begin
                found_q    <= 1'b1;
                hit_base_q <= head.base;
                hit_off_q  <= pos_q[wrpp_pkg::SIZE_W-1:0];
              end else begin
                pos_q <= pos_q - head_len;
              end
            end
          end else begin
            // walk over, settle the result
            if (kind_q == wrpp_pkg::KIND_DELETE) begin
              if (found_q) begin
                count_q      <= count_q - CW'(1);
                res_status_q <= wrpp_pkg::ST_OK;
              end else begin
                res_status_q <= wrpp_pkg::ST_NOT_FOUND;
              end
            end else if (found_q && (total_q != '0)) begin
              res_status_q <= wrpp_pkg::ST_OK;
              res_addr_q   <= hit_page;
            end else begin
              res_status_q <= wrpp_pkg::ST_NOT_FOUND;
            end
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_total_q  <= total_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_addr_q;
  assign status_o       = out_status_q;
  assign total_bytes_o  = out_total_q;

endmodule
